// ===== rtl/sdi_pkg.sv =====
package sdi_pkg;

    // Result actions.
    localparam logic [1:0] ACT_ISSUE = 2'd0;
    localparam logic [1:0] ACT_DONE  = 2'd1;
    localparam logic [1:0] ACT_FAIL  = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_CMD       = 2'd1;
    localparam logic [1:0] ERR_OP_TMO    = 2'd2;
    localparam logic [1:0] ERR_BUS_WIDTH = 2'd3;

    // Expected response kinds.
    localparam logic [2:0] RK_NONE = 3'd0;
    localparam logic [2:0] RK_R1   = 3'd1;
    localparam logic [2:0] RK_R1B  = 3'd2;
    localparam logic [2:0] RK_R2   = 3'd3;
    localparam logic [2:0] RK_R3   = 3'd4;
    localparam logic [2:0] RK_R6   = 3'd5;
    localparam logic [2:0] RK_R7   = 3'd6;

    // SD command numbers.
    localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
    localparam logic [5:0] CMD_ALL_CID     = 6'd2;
    localparam logic [5:0] CMD_REL_ADDR    = 6'd3;
    localparam logic [5:0] ACMD_BUS_WIDTH  = 6'd6;
    localparam logic [5:0] CMD_SELECT      = 6'd7;
    localparam logic [5:0] CMD_IF_COND     = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD    = 6'd9;
    localparam logic [5:0] ACMD_OP_COND    = 6'd41;
    localparam logic [5:0] ACMD_SEND_SCR   = 6'd51;
    localparam logic [5:0] CMD_APP         = 6'd55;

    // Request types.
    localparam logic REQ_START = 1'b0;

    // Argument and status constants.
    localparam logic [31:0] IF_COND_ARG     = 32'h0000_01AA;
    localparam logic [31:0] BUS_4BIT_ARG    = 32'h0000_0002;
    localparam logic [31:0] SW_STATUS_MASK  = 32'hFFF8_0000;
    localparam logic [3:0]  SCR_BYTES       = 4'd8;
    localparam logic [15:0] RETRY_RESET     = 16'd1000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IDX_3V3   = 2'd0;
    localparam logic [1:0] CFG_IDX_3V0   = 2'd1;
    localparam logic [1:0] CFG_IDX_RETRY = 2'd2;

    // Reciprocal of 1000 scaled by 2^38, rounded up; exact for 32-bit dividends.
    localparam logic [28:0] DIV1000_MAGIC = 29'd274877907;
    localparam int          DIV1000_SHIFT = 38;

    typedef struct packed {
        logic        req_type;
        logic        cmd_ok;
        logic [63:0] resp_low;
        logic [63:0] resp_high;
        logic [31:0] scr_word;
    } item_t;

    typedef struct packed {
        logic        sup_3v3;
        logic        sup_3v0;
        logic [15:0] retry_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  error_code;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_arg;
        logic [2:0]  resp_kind;
        logic [3:0]  data_bytes;
    } cmd_t;

    typedef struct packed {
        logic [31:0] card_size_kb;
        logic        high_capacity;
        logic [15:0] card_address;
        logic        wide_bus;
        logic        spec_v2;
    } status_t;

endpackage

// ===== rtl/sdi_csd_size.sv =====
module sdi_csd_size (
    input  logic [63:0] resp_low,
    input  logic [63:0] resp_high,
    output logic [31:0] size_kb
);
    import sdi_pkg::*;

    logic        csd_v2;
    logic [22:0] v2_blocks;
    logic [12:0] v1_blocks;
    logic [2:0]  v1_mult;
    logic [3:0]  v1_bl_len;
    logic [4:0]  v1_shamt;
    logic [31:0] v1_bytes;
    logic [60:0] v1_scaled;

    // The CSD structure field sits in the top two bits of byte 14.
    assign csd_v2 = (resp_high[55:54] == 2'b01);

    // Version 2: capacity is (C_SIZE + 1) * 512 kilobytes.
    assign v2_blocks = {1'b0, resp_low[61:40]} + 23'd1;

    // Version 1: bytes are (C_SIZE + 1) shifted left by the size multiplier field plus two
    // plus the block length exponent, kept to 32 bits.
    assign v1_blocks = {1'b0, resp_high[9:0], resp_low[63:62]} + 13'd1;
    assign v1_mult   = resp_low[49:47];
    assign v1_bl_len = resp_high[19:16];
    assign v1_shamt  = {2'b00, v1_mult} + 5'd2 + {1'b0, v1_bl_len};
    assign v1_bytes  = {19'd0, v1_blocks} << v1_shamt;

    // Division by 1000 is a multiply by the scaled reciprocal and a shift.
    assign v1_scaled = {29'd0, v1_bytes} * {32'd0, DIV1000_MAGIC};

    assign size_kb = csd_v2 ? {v2_blocks, 9'd0}
                            : {9'd0, v1_scaled[60:DIV1000_SHIFT]};

endmodule

// ===== rtl/sdi_ctrl.sv =====
module sdi_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  sdi_pkg::cfg_t   cfg,
    input  logic            item_vld,
    input  sdi_pkg::item_t  item,
    output logic            item_take,
    output logic            out_vld,
    input  logic            out_rdy,
    output sdi_pkg::cmd_t   out_cmd,
    output sdi_pkg::status_t status
);
    import sdi_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_W0, ST_W8, ST_W55OP, ST_W41, ST_W2, ST_W3, ST_W9,
        ST_W7, ST_W55SCR, ST_W51, ST_W55BW, ST_W6, ST_DONE, ST_FAIL
    } stage_t;

    stage_t      stage_reg, stage_next;
    logic [15:0] retries_reg, retries_next;
    logic        v2_reg, v2_next;
    logic        hcap_reg, hcap_next;
    logic [15:0] rca_reg, rca_next;
    logic [31:0] size_reg, size_next;
    logic        bus4_reg, bus4_next;
    logic        out_vld_reg, out_vld_next;
    cmd_t        out_reg, out_next;

    logic        has_result;
    logic        advance;
    logic [31:0] r0;
    logic [31:0] addr;
    logic [31:0] op_arg;
    logic [31:0] csd_size;

    function automatic cmd_t make_cmd(input logic [5:0] idx, input logic [31:0] arg,
                                      input logic [2:0] rk, input logic [3:0] nb);
        cmd_t c;
        c.action     = ACT_ISSUE;
        c.error_code = ERR_NONE;
        c.cmd_index  = idx;
        c.cmd_arg    = arg;
        c.resp_kind  = rk;
        c.data_bytes = nb;
        return c;
    endfunction

    function automatic cmd_t make_end(input logic [1:0] err);
        cmd_t c;
        c            = '0;
        c.action     = (err == ERR_NONE) ? ACT_DONE : ACT_FAIL;
        c.error_code = err;
        return c;
    endfunction

    sdi_csd_size u_csd_size (
        .resp_low  (item.resp_low),
        .resp_high (item.resp_high),
        .size_kb   (csd_size)
    );

    assign r0   = item.resp_low[31:0];
    assign addr = {rca_reg, 16'd0};

    // ACMD41 argument: HCS when the card passed CMD8, plus the host voltage windows.
    assign op_arg = {1'b0, v2_reg, 8'd0, {2{cfg.sup_3v3}}, 1'b0, {2{cfg.sup_3v0}}, 17'd0};

    // Next-state and result selection for the item held in the input register.
    always_comb begin
        stage_next   = stage_reg;
        retries_next = retries_reg;
        v2_next      = v2_reg;
        hcap_next    = hcap_reg;
        rca_next     = rca_reg;
        size_next    = size_reg;
        bus4_next    = bus4_reg;
        out_next     = '0;
        has_result   = 1'b0;

        if (item.req_type == REQ_START) begin
            retries_next = '0;
            v2_next      = 1'b0;
            hcap_next    = 1'b0;
            rca_next     = '0;
            size_next    = '0;
            bus4_next    = 1'b0;
            stage_next   = ST_W0;
            out_next     = make_cmd(CMD_GO_IDLE, '0, RK_NONE, '0);
            has_result   = 1'b1;
        end else if (stage_reg == ST_W8) begin
            // A failed CMD8 simply marks the card as version 1.
            v2_next      = item.cmd_ok && ((r0 & IF_COND_ARG) == IF_COND_ARG);
            retries_next = cfg.retry_limit;
            stage_next   = ST_W55OP;
            out_next     = make_cmd(CMD_APP, addr, RK_R1, '0);
            has_result   = 1'b1;
        end else if (stage_reg == ST_IDLE || stage_reg == ST_DONE || stage_reg == ST_FAIL) begin
            // Nothing outstanding: the completion is dropped.
            has_result = 1'b0;
        end else if (!item.cmd_ok) begin
            stage_next = ST_FAIL;
            out_next   = make_end(ERR_CMD);
            has_result = 1'b1;
        end else begin
            has_result = 1'b1;
            unique case (stage_reg)
                ST_W0: begin
                    stage_next = ST_W8;
                    out_next   = make_cmd(CMD_IF_COND, IF_COND_ARG, RK_R7, '0);
                end
                ST_W55OP: begin
                    stage_next = ST_W41;
                    out_next   = make_cmd(ACMD_OP_COND, op_arg, RK_R3, '0);
                end
                ST_W41: begin
                    if (r0[31]) begin
                        hcap_next  = r0[30];
                        stage_next = ST_W2;
                        out_next   = make_cmd(CMD_ALL_CID, '0, RK_R2, '0);
                    end else if (retries_reg <= 16'd1) begin
                        retries_next = '0;
                        stage_next   = ST_FAIL;
                        out_next     = make_end(ERR_OP_TMO);
                    end else begin
                        retries_next = retries_reg - 16'd1;
                        stage_next   = ST_W55OP;
                        out_next     = make_cmd(CMD_APP, addr, RK_R1, '0);
                    end
                end
                ST_W2: begin
                    stage_next = ST_W3;
                    out_next   = make_cmd(CMD_REL_ADDR, '0, RK_R6, '0);
                end
                ST_W3: begin
                    rca_next   = r0[31:16];
                    stage_next = ST_W9;
                    out_next   = make_cmd(CMD_SEND_CSD, {r0[31:16], 16'd0}, RK_R2, '0);
                end
                ST_W9: begin
                    size_next  = csd_size;
                    stage_next = ST_W7;
                    out_next   = make_cmd(CMD_SELECT, addr, RK_R1B, '0);
                end
                ST_W7: begin
                    stage_next = ST_W55SCR;
                    out_next   = make_cmd(CMD_APP, addr, RK_R1, '0);
                end
                ST_W55SCR: begin
                    stage_next = ST_W51;
                    out_next   = make_cmd(ACMD_SEND_SCR, '0, RK_R1, SCR_BYTES);
                end
                ST_W51: begin
                    // Bit 18 of the byte-swapped SCR word is bit 10 as loaded.
                    if (item.scr_word[10]) begin
                        stage_next = ST_W55BW;
                        out_next   = make_cmd(CMD_APP, addr, RK_R1, '0);
                    end else begin
                        stage_next = ST_DONE;
                        out_next   = make_end(ERR_NONE);
                    end
                end
                ST_W55BW: begin
                    stage_next = ST_W6;
                    out_next   = make_cmd(ACMD_BUS_WIDTH, BUS_4BIT_ARG, RK_R1, '0);
                end
                ST_W6: begin
                    if ((r0 & SW_STATUS_MASK) != '0) begin
                        stage_next = ST_FAIL;
                        out_next   = make_end(ERR_BUS_WIDTH);
                    end else begin
                        bus4_next  = 1'b1;
                        stage_next = ST_DONE;
                        out_next   = make_end(ERR_NONE);
                    end
                end
                default: begin
                    has_result = 1'b0;
                end
            endcase
        end
    end

    // An item moves on when it yields nothing or the result register is free.
    assign advance   = item_vld && (!has_result || !out_vld_reg || out_rdy);
    assign item_take = advance;

    always_comb begin
        if (advance && has_result) begin
            out_vld_next = 1'b1;
        end else if (out_rdy) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    // State and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg   <= ST_IDLE;
            retries_reg <= '0;
            v2_reg      <= 1'b0;
            hcap_reg    <= 1'b0;
            rca_reg     <= '0;
            size_reg    <= '0;
            bus4_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
            if (advance) begin
                stage_reg   <= stage_next;
                retries_reg <= retries_next;
                v2_reg      <= v2_next;
                hcap_reg    <= hcap_next;
                rca_reg     <= rca_next;
                size_reg    <= size_next;
                bus4_reg    <= bus4_next;
            end
        end
        if (advance && has_result) begin
            out_reg <= out_next;
        end
    end

    // State only moves with a result load, so it matches the result on display.
    assign out_vld = out_vld_reg;
    assign out_cmd = out_reg;
    assign status.card_size_kb  = size_reg;
    assign status.high_capacity = hcap_reg;
    assign status.card_address  = rca_reg;
    assign status.wide_bus      = bus4_reg;
    assign status.spec_v2       = v2_reg;

    // A start item always yields CMD0 as its result.
    a_start_cmd0: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item.req_type == REQ_START) |=>
            (out_vld_reg && out_reg.action == ACT_ISSUE && out_reg.cmd_index == CMD_GO_IDLE))
        else $error("start item did not yield CMD0");

    // Done and failed results carry no command.
    a_end_no_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_reg.action != ACT_ISSUE) |->
            (out_reg.cmd_index == '0 && out_reg.cmd_arg == '0 && out_reg.resp_kind == RK_NONE))
        else $error("end result carries a command");

    // The stage agrees with the kind of result just loaded.
    a_stage_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && has_result) |=>
            ((stage_reg == ST_DONE) == (out_reg.action == ACT_DONE) &&
             (stage_reg == ST_FAIL) == (out_reg.action == ACT_FAIL)))
        else $error("stage and result action disagree");

    // The 4-bit flag only comes up on the way to done.
    a_bus4_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(bus4_reg) |-> (stage_reg == ST_DONE))
        else $error("wide bus set outside completion");

endmodule

// ===== rtl/sd_card_init_sequencer.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  req_type, cmd_ok, resp_low, resp_high, scr_word
// m_        out        m_valid / m_ready  action, error_code, cmd_index, cmd_arg, resp_kind,
//                                         data_bytes, card_size_kb, high_capacity,
//                                         card_address, wide_bus, spec_v2
// cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// One item is taken per cycle while the m_ side takes results; its result is loaded into
// the result register from the input register when the item moves on.
// The rate is set by the single decision stage between the input and result registers.
// A completion with nothing outstanding leaves the input register without a result.
// A stalled m_ side holds the result and, behind it, one item in the input register.
// Reset (aresetn, synchronous, active low) clears the sequence to idle and loads the
// register defaults.
module sd_card_init_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic        s_cmd_ok,
    input  logic [63:0] s_resp_low,
    input  logic [63:0] s_resp_high,
    input  logic [31:0] s_scr_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_action,
    output logic [1:0]  m_error_code,
    output logic [5:0]  m_cmd_index,
    output logic [31:0] m_cmd_arg,
    output logic [2:0]  m_resp_kind,
    output logic [3:0]  m_data_bytes,
    output logic [31:0] m_card_size_kb,
    output logic        m_high_capacity,
    output logic [15:0] m_card_address,
    output logic        m_wide_bus,
    output logic        m_spec_v2
);
    import sdi_pkg::*;

    cfg_t    cfg_reg;
    logic    in_vld_reg;
    item_t   item_reg;
    logic    item_take;
    cmd_t    out_cmd;
    status_t status;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sup_3v3     <= 1'b1;
            cfg_reg.sup_3v0     <= 1'b1;
            cfg_reg.retry_limit <= RETRY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IDX_3V3:   cfg_reg.sup_3v3     <= cfg_wdata[0];
                CFG_IDX_3V0:   cfg_reg.sup_3v0     <= cfg_wdata[0];
                CFG_IDX_RETRY: cfg_reg.retry_limit <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register: refilled in the same cycle its item moves on.
    assign s_ready = !in_vld_reg || item_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            item_reg.req_type  <= s_req_type;
            item_reg.cmd_ok    <= s_cmd_ok;
            item_reg.resp_low  <= s_resp_low;
            item_reg.resp_high <= s_resp_high;
            item_reg.scr_word  <= s_scr_word;
        end
    end

    sdi_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .item_vld  (in_vld_reg),
        .item      (item_reg),
        .item_take (item_take),
        .out_vld   (m_valid),
        .out_rdy   (m_ready),
        .out_cmd   (out_cmd),
        .status    (status)
    );

    assign m_action        = out_cmd.action;
    assign m_error_code    = out_cmd.error_code;
    assign m_cmd_index     = out_cmd.cmd_index;
    assign m_cmd_arg       = out_cmd.cmd_arg;
    assign m_resp_kind     = out_cmd.resp_kind;
    assign m_data_bytes    = out_cmd.data_bytes;
    assign m_card_size_kb  = status.card_size_kb;
    assign m_high_capacity = status.high_capacity;
    assign m_card_address  = status.card_address;
    assign m_wide_bus      = status.wide_bus;
    assign m_spec_v2       = status.spec_v2;

endmodule

// ===== dv/tb_sd_card_init_sequencer.sv =====
module tb_sd_card_init_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import sdi_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int RUN_LIMIT_NS   = 5_000_000;

    // Random phases: one register setting each, extremes included.
    localparam int PHASES         = 6;
    localparam int PHASE_REPLIES  = 215;
    localparam int HOLD_PHASE     = 1;
    localparam int STEADY_PHASE   = 2;
    localparam logic [PHASES-1:0] PHASE_3V3 = 6'b110101;
    localparam logic [PHASES-1:0] PHASE_3V0 = 6'b110011;
    localparam logic [PHASES-1:0][15:0] PHASE_LIMIT =
        {16'd0, 16'd1000, 16'd3, 16'hFFFF, 16'd2, 16'd1};

    // A completion item; the package only names the start request.
    localparam logic REQ_DONE = 1'b1;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_WAIT_GO_IDLE,
        SEQ_WAIT_IF_COND,
        SEQ_WAIT_APP_OP,
        SEQ_WAIT_OP_COND,
        SEQ_WAIT_CID,
        SEQ_WAIT_RCA,
        SEQ_WAIT_CSD,
        SEQ_WAIT_SELECT,
        SEQ_WAIT_APP_SCR,
        SEQ_WAIT_SCR,
        SEQ_WAIT_APP_BUS,
        SEQ_WAIT_BUS,
        SEQ_DONE,
        SEQ_FAILED
    } seq_stage_t;

    typedef struct packed {
        cmd_t    cmd;
        status_t status;
    } reply_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_PINNED,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  cfg_idx;
        logic [15:0] cfg_val;
        item_t       item;
        cmd_t        pin;
    } plan_row_t;

    localparam item_t NO_ITEM = '0;
    localparam cmd_t  NO_CMD  = '0;
    localparam int    PLAN_LEN = 27;

    // Directed opening. Pinned rows carry the command half of the result as it
    // reads straight off the behaviour; the card status always comes from the
    // predictor below.
    plan_row_t plan [PLAN_LEN] = '{
        // Completion with nothing outstanding after reset.
        {ROW_ITEM, 18'd0, REQ_DONE, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
         64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, NO_CMD},
        {ROW_PINNED, 18'd0, REQ_START, 1'b0, 64'h0, 64'h0, 32'h0,
         ACT_ISSUE, ERR_NONE, CMD_GO_IDLE, 32'h0, RK_NONE, 4'd0},
        {ROW_PINNED, 18'd0, REQ_DONE, 1'b1, 64'h0, 64'h0, 32'h0,
         ACT_ISSUE, ERR_NONE, CMD_IF_COND, IF_COND_ARG, RK_R7, 4'd0},
        {ROW_PINNED, 18'd0, REQ_DONE, 1'b1, 64'h0000_0000_0000_01AA, 64'h0, 32'h0,
         ACT_ISSUE, ERR_NONE, CMD_APP, 32'h0, RK_R1, 4'd0},
        {ROW_PINNED, 18'd0, REQ_DONE, 1'b1, 64'h0, 64'h0, 32'h0,
         ACT_ISSUE, ERR_NONE, ACMD_OP_COND, 32'h4036_0000, RK_R3, 4'd0},
        // Card still busy, then the retry.
        {ROW_ITEM, 18'd0, REQ_DONE, 1'b1, 64'hFFFF_FFFF_7FFF_FFFF, 64'h0, 32'h0, NO_CMD},
        {ROW_ITEM, 18'd0, REQ_DONE, 1'b1, 64'h0, 64'h0, 32'h0, NO_CMD},
        {ROW_PINNED, 18'd0, REQ_DONE, 1'b1, 64'h0000_0000_C000_0000, 64'h0, 32'h0,
         ACT_ISSUE, ERR_NONE, CMD_ALL_CID, 32'h0, RK_R2, 4'd0},
        {ROW_PINNED, 18'd0, REQ_DONE, 1'b1, 64'h0, 64'h0, 32'h0,
         ACT_ISSUE, ERR_NONE, CMD_REL_ADDR, 32'h0, RK_R6, 4'd0},
        {ROW_PINNED, 18'd0, REQ_DONE, 1'b1, 64'h0000_0000_FFFF_0000, 64'h0, 32'h0,
         ACT_ISSUE, ERR_NONE, CMD_SEND_CSD, 32'hFFFF_0000, RK_R2, 4'd0},
        // Version 2 CSD with the largest C_SIZE.
        {ROW_ITEM, 18'd0, REQ_DONE, 1'b1, 64'hFFFF_FF00_0000_0000,
         64'h0040_0000_0000_0000, 32'h0, NO_CMD},
        {ROW_ITEM, 18'd0, REQ_DONE, 1'b1, 64'h0, 64'h0, 32'h0, NO_CMD},
        {ROW_PINNED, 18'd0, REQ_DONE, 1'b1, 64'h0, 64'h0, 32'h0,
         ACT_ISSUE, ERR_NONE, ACMD_SEND_SCR, 32'h0, RK_R1, SCR_BYTES},
        {ROW_ITEM, 18'd0, REQ_DONE, 1'b1, 64'h0, 64'h0, 32'hFFFF_FFFF, NO_CMD},
        {ROW_PINNED, 18'd0, REQ_DONE, 1'b1, 64'h0, 64'h0, 32'h0,
         ACT_ISSUE, ERR_NONE, ACMD_BUS_WIDTH, BUS_4BIT_ARG, RK_R1, 4'd0},
        // Bus width switch refused by the card status.
        {ROW_PINNED, 18'd0, REQ_DONE, 1'b1, 64'h0000_0000_FFF8_0000, 64'h0, 32'h0,
         ACT_FAIL, ERR_BUS_WIDTH, 6'd0, 32'h0, RK_NONE, 4'd0},
        {ROW_ITEM, 18'd0, REQ_DONE, 1'b1, 64'h0, 64'h0, 32'h0, NO_CMD},
        {ROW_PINNED, 18'd0, REQ_START, 1'b1, 64'h0, 64'h0, 32'h0,
         ACT_ISSUE, ERR_NONE, CMD_GO_IDLE, 32'h0, RK_NONE, 4'd0},
        {ROW_PINNED, 18'd0, REQ_DONE, 1'b1, 64'h0, 64'h0, 32'h0,
         ACT_ISSUE, ERR_NONE, CMD_IF_COND, IF_COND_ARG, RK_R7, 4'd0},
        // Restart in the middle of the sequence, then a failed transfer.
        {ROW_PINNED, 18'd0, REQ_START, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 32'h0,
         ACT_ISSUE, ERR_NONE, CMD_GO_IDLE, 32'h0, RK_NONE, 4'd0},
        {ROW_PINNED, 18'd0, REQ_DONE, 1'b0, 64'h0, 64'h0, 32'h0,
         ACT_FAIL, ERR_CMD, 6'd0, 32'h0, RK_NONE, 4'd0},
        // No voltage windows and a retry limit of zero.
        {ROW_CFG, CFG_IDX_3V3, 16'hFFFE, NO_ITEM, NO_CMD},
        {ROW_CFG, CFG_IDX_3V0, 16'h0000, NO_ITEM, NO_CMD},
        {ROW_CFG, CFG_IDX_RETRY, 16'h0000, NO_ITEM, NO_CMD},
        {ROW_PINNED, 18'd0, REQ_START, 1'b0, 64'h0, 64'h0, 32'h0,
         ACT_ISSUE, ERR_NONE, CMD_GO_IDLE, 32'h0, RK_NONE, 4'd0},
        {ROW_PINNED, 18'd0, REQ_DONE, 1'b1, 64'h0, 64'h0, 32'h0,
         ACT_ISSUE, ERR_NONE, CMD_IF_COND, IF_COND_ARG, RK_R7, 4'd0},
        // CMD8 transfer failure marks a version 1 card and carries on.
        {ROW_PINNED, 18'd0, REQ_DONE, 1'b0, 64'h0000_0000_0000_01AA, 64'h0, 32'h0,
         ACT_ISSUE, ERR_NONE, CMD_APP, 32'h0, RK_R1, 4'd0}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    item_t       drv_item;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_action;
    logic [1:0]  m_error_code;
    logic [5:0]  m_cmd_index;
    logic [31:0] m_cmd_arg;
    logic [2:0]  m_resp_kind;
    logic [3:0]  m_data_bytes;
    logic [31:0] m_card_size_kb;
    logic        m_high_capacity;
    logic [15:0] m_card_address;
    logic        m_wide_bus;
    logic        m_spec_v2;

    // Pinned command for the item on offer, read back when it is accepted.
    bit          drv_pinned;
    cmd_t        drv_pin;

    // Predicted card and sequence state, with its own copy of the registers.
    logic        host_3v3;
    logic        host_3v0;
    logic [15:0] op_cond_limit;
    seq_stage_t  seq_stage;
    logic [15:0] retries_left;
    logic        card_v2;
    logic        card_hc;
    logic [15:0] card_rca;
    logic [31:0] card_kb;
    logic        card_wide;

    reply_t      pending_replies[$];
    int          replies_due_total = 0;
    int          failures = 0;
    bit          steady = 1'b0;
    int          hold_requests = 0;

    always #HALF_PERIOD aclk = ~aclk;

    sd_card_init_sequencer uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (drv_item.req_type),
        .s_cmd_ok        (drv_item.cmd_ok),
        .s_resp_low      (drv_item.resp_low),
        .s_resp_high     (drv_item.resp_high),
        .s_scr_word      (drv_item.scr_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_action        (m_action),
        .m_error_code    (m_error_code),
        .m_cmd_index     (m_cmd_index),
        .m_cmd_arg       (m_cmd_arg),
        .m_resp_kind     (m_resp_kind),
        .m_data_bytes    (m_data_bytes),
        .m_card_size_kb  (m_card_size_kb),
        .m_high_capacity (m_high_capacity),
        .m_card_address  (m_card_address),
        .m_wide_bus      (m_wide_bus),
        .m_spec_v2       (m_spec_v2)
    );

    // Queue the next command together with the card status as it now stands.
    task automatic expect_command(input seq_stage_t next, input logic [5:0] idx,
                                  input logic [31:0] arg, input logic [2:0] rk,
                                  input logic [3:0] nbytes);
        reply_t r;
        seq_stage = next;
        r.cmd = {ACT_ISSUE, ERR_NONE, idx, arg, rk, nbytes};
        r.status = {card_kb, card_hc, card_rca, card_wide, card_v2};
        pending_replies.push_back(r);
        replies_due_total++;
    endtask

    // Queue the end of enumeration, done or failed.
    task automatic expect_outcome(input logic [1:0] err);
        reply_t r;
        seq_stage = (err == ERR_NONE) ? SEQ_DONE : SEQ_FAILED;
        r.cmd = {(err == ERR_NONE) ? ACT_DONE : ACT_FAIL, err, 6'd0, 32'h0, RK_NONE, 4'd0};
        r.status = {card_kb, card_hc, card_rca, card_wide, card_v2};
        pending_replies.push_back(r);
        replies_due_total++;
    endtask

    // Work out the block's answer to one accepted item.
    task automatic predict_next_command(input item_t it);
        logic [127:0] csd;
        logic [31:0]  r0;
        logic [31:0]  addr;
        logic [31:0]  c_size;
        logic [31:0]  product;
        logic [31:0]  scr;
        logic [4:0]   shift;
        r0 = it.resp_low[31:0];
        addr = {card_rca, 16'h0000};
        csd = {it.resp_high, it.resp_low};
        scr = {it.scr_word[7:0], it.scr_word[15:8], it.scr_word[23:16], it.scr_word[31:24]};
        if (it.req_type == REQ_START) begin
            retries_left = '0;
            card_v2 = 1'b0;
            card_hc = 1'b0;
            card_rca = '0;
            card_kb = '0;
            card_wide = 1'b0;
            expect_command(SEQ_WAIT_GO_IDLE, CMD_GO_IDLE, 32'h0, RK_NONE, 4'd0);
        end else if (seq_stage == SEQ_IDLE || seq_stage == SEQ_DONE ||
                     seq_stage == SEQ_FAILED) begin
            // Nothing outstanding: the completion is dropped without a result.
        end else if (seq_stage == SEQ_WAIT_IF_COND) begin
            // A bad or missing CMD8 answer only means a version 1 card.
            card_v2 = it.cmd_ok && ((r0 & IF_COND_ARG) == IF_COND_ARG);
            retries_left = op_cond_limit;
            expect_command(SEQ_WAIT_APP_OP, CMD_APP, addr, RK_R1, 4'd0);
        end else if (!it.cmd_ok) begin
            expect_outcome(ERR_CMD);
        end else begin
            case (seq_stage)
                SEQ_WAIT_GO_IDLE: begin
                    expect_command(SEQ_WAIT_IF_COND, CMD_IF_COND, IF_COND_ARG, RK_R7, 4'd0);
                end
                SEQ_WAIT_APP_OP: begin
                    expect_command(SEQ_WAIT_OP_COND, ACMD_OP_COND,
                                   {1'b0, card_v2, 8'h00, host_3v3, host_3v3, 1'b0,
                                    host_3v0, host_3v0, 17'h0},
                                   RK_R3, 4'd0);
                end
                SEQ_WAIT_OP_COND: begin
                    if (r0[31]) begin
                        card_hc = r0[30];
                        expect_command(SEQ_WAIT_CID, CMD_ALL_CID, 32'h0, RK_R2, 4'd0);
                    end else if (retries_left <= 16'd1) begin
                        retries_left = '0;
                        expect_outcome(ERR_OP_TMO);
                    end else begin
                        retries_left = retries_left - 16'd1;
                        expect_command(SEQ_WAIT_APP_OP, CMD_APP, addr, RK_R1, 4'd0);
                    end
                end
                SEQ_WAIT_CID: begin
                    expect_command(SEQ_WAIT_RCA, CMD_REL_ADDR, 32'h0, RK_R6, 4'd0);
                end
                SEQ_WAIT_RCA: begin
                    card_rca = r0[31:16];
                    expect_command(SEQ_WAIT_CSD, CMD_SEND_CSD, {card_rca, 16'h0000},
                                   RK_R2, 4'd0);
                end
                SEQ_WAIT_CSD: begin
                    // Capacity: version 2 counts 512 KB units, version 1 is a
                    // shifted block count that wraps at 32 bits, then divided by 1000.
                    if (csd[119:118] == 2'b01) begin
                        c_size = {10'd0, csd[61:40]};
                        card_kb = (c_size + 32'd1) << 9;
                    end else begin
                        c_size = {20'd0, csd[73:62]};
                        shift = 5'(csd[49:47]) + 5'd2 + 5'(csd[83:80]);
                        product = (c_size + 32'd1) << shift;
                        card_kb = product / 32'd1000;
                    end
                    expect_command(SEQ_WAIT_SELECT, CMD_SELECT, addr, RK_R1B, 4'd0);
                end
                SEQ_WAIT_SELECT: begin
                    expect_command(SEQ_WAIT_APP_SCR, CMD_APP, addr, RK_R1, 4'd0);
                end
                SEQ_WAIT_APP_SCR: begin
                    expect_command(SEQ_WAIT_SCR, ACMD_SEND_SCR, 32'h0, RK_R1, SCR_BYTES);
                end
                SEQ_WAIT_SCR: begin
                    if (scr[18]) begin
                        expect_command(SEQ_WAIT_APP_BUS, CMD_APP, addr, RK_R1, 4'd0);
                    end else begin
                        expect_outcome(ERR_NONE);
                    end
                end
                SEQ_WAIT_APP_BUS: begin
                    expect_command(SEQ_WAIT_BUS, ACMD_BUS_WIDTH, BUS_4BIT_ARG, RK_R1, 4'd0);
                end
                SEQ_WAIT_BUS: begin
                    if ((r0 & SW_STATUS_MASK) != 32'h0) begin
                        expect_outcome(ERR_BUS_WIDTH);
                    end else begin
                        card_wide = 1'b1;
                        expect_outcome(ERR_NONE);
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            failures++;
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // Check each result against the oldest expectation, then predict for the
    // item taken at the same edge.
    always @(posedge aclk) begin : result_check
        reply_t want;
        int     depth;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    failures++;
                    $display("%0t: result expected none, got action %0d command %0d",
                             $time, m_action, m_cmd_index);
                end else begin
                    want = pending_replies.pop_front();
                    check_field("action", 32'(want.cmd.action), 32'(m_action));
                    check_field("error_code", 32'(want.cmd.error_code), 32'(m_error_code));
                    check_field("cmd_index", 32'(want.cmd.cmd_index), 32'(m_cmd_index));
                    check_field("cmd_arg", want.cmd.cmd_arg, m_cmd_arg);
                    check_field("resp_kind", 32'(want.cmd.resp_kind), 32'(m_resp_kind));
                    check_field("data_bytes", 32'(want.cmd.data_bytes), 32'(m_data_bytes));
                    check_field("card_size_kb", want.status.card_size_kb, m_card_size_kb);
                    check_field("high_capacity", 32'(want.status.high_capacity),
                                32'(m_high_capacity));
                    check_field("card_address", 32'(want.status.card_address),
                                32'(m_card_address));
                    check_field("wide_bus", 32'(want.status.wide_bus), 32'(m_wide_bus));
                    check_field("spec_v2", 32'(want.status.spec_v2), 32'(m_spec_v2));
                end
            end
            if (s_valid && s_ready) begin
                depth = pending_replies.size();
                predict_next_command(drv_item);
                if (drv_pinned && pending_replies.size() > depth) begin
                    want = pending_replies.pop_back();
                    want.cmd = drv_pin;
                    pending_replies.push_back(want);
                end
            end
        end
    end

    // Result side: random stalls, a long hold when asked, none in steady runs.
    initial begin : result_sink
        int served;
        served = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (served != hold_requests) begin
                served++;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= steady || ($urandom_range(0, 99) >= 33);
        end
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    // Offer one item from a falling edge and return at the falling edge after
    // it is taken. Valid only drops when a gap is inserted.
    task automatic offer(input item_t it, input bit pinned, input cmd_t pin);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 33) begin
            gap = $urandom_range(1, 4);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        drv_item <= it;
        drv_pinned <= pinned;
        drv_pin <= pin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Hold the input until every expected result is out and the block is quiet.
    task automatic quiesce();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_IDX_3V3:   host_3v3 = value[0];
            CFG_IDX_3V0:   host_3v0 = value[0];
            CFG_IDX_RETRY: op_cond_limit = value;
            default: begin
            end
        endcase
        @(negedge aclk);
    endtask

    // A completion shaped to push the sequence forward from the predicted
    // stage, with random content and the odd restart or failed transfer.
    function automatic item_t draw_completion();
        item_t it;
        it.req_type = REQ_DONE;
        it.cmd_ok = 1'b1;
        it.resp_low = {$urandom, $urandom};
        it.resp_high = {$urandom, $urandom};
        it.scr_word = $urandom;
        if (seq_stage == SEQ_IDLE || seq_stage == SEQ_DONE || seq_stage == SEQ_FAILED) begin
            if ($urandom_range(0, 9) != 0) begin
                it.req_type = REQ_START;
                it.cmd_ok = 1'($urandom);
            end
        end else if ($urandom_range(0, 99) < 2) begin
            it.req_type = REQ_START;
        end else if ($urandom_range(0, 99) < 3) begin
            it.cmd_ok = 1'b0;
        end else begin
            case (seq_stage)
                SEQ_WAIT_IF_COND: begin
                    case ($urandom_range(0, 9))
                        7: it.cmd_ok = 1'b0;
                        8, 9: begin
                        end
                        default: it.resp_low[31:0] = it.resp_low[31:0] | IF_COND_ARG;
                    endcase
                end
                SEQ_WAIT_OP_COND: it.resp_low[31] = ($urandom_range(0, 99) < 35);
                SEQ_WAIT_CSD: begin
                    if ($urandom_range(0, 1) != 0) begin
                        it.resp_high[55:54] = 2'b01;
                    end
                end
                SEQ_WAIT_BUS: begin
                    if ($urandom_range(0, 1) != 0) begin
                        it.resp_low[31:19] = '0;
                    end
                end
                default: begin
                end
            endcase
        end
        return it;
    endfunction

    initial begin : stimulus
        int goal;
        int n;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        drv_item = '0;
        drv_pinned = 1'b0;
        drv_pin = '0;
        host_3v3 = 1'b1;
        host_3v0 = 1'b1;
        op_cond_limit = RETRY_RESET;
        seq_stage = SEQ_IDLE;
        retries_left = '0;
        card_v2 = 1'b0;
        card_hc = 1'b0;
        card_rca = '0;
        card_kb = '0;
        card_wide = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed opening.
        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == ROW_CFG) begin
                quiesce();
                write_register(plan[i].cfg_idx, plan[i].cfg_val);
            end else begin
                offer(plan[i].item, plan[i].kind == ROW_PINNED, plan[i].pin);
            end
        end

        // Random sequences, one register setting per phase.
        for (int p = 0; p < PHASES; p++) begin
            quiesce();
            write_register(CFG_IDX_3V3, {15'($urandom), PHASE_3V3[p]});
            write_register(CFG_IDX_3V0, {15'($urandom), PHASE_3V0[p]});
            write_register(CFG_IDX_RETRY, PHASE_LIMIT[p]);
            steady = (p == STEADY_PHASE);
            goal = replies_due_total + PHASE_REPLIES;
            n = 0;
            while (replies_due_total < goal) begin
                if (p == HOLD_PHASE && n == 40) begin
                    hold_requests++;
                end
                offer(draw_completion(), 1'b0, NO_CMD);
                n++;
            end
            steady = 1'b0;
        end

        quiesce();
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
